// ----- rtl/core/swpa_pkg.sv -----
package swpa_pkg;

    localparam int CONST_FRAC = 30;
    localparam int NUM_REGS = 8;
    localparam int IDX_W = 3;

    // Coefficients of C1, C3, C5, C7 as cubics in d, constant term first, Q.30
    localparam logic signed [31:0] COEF_TAB [4][4] = '{
        '{32'sd1686842346, 32'sd605904980, -32'sd191518789, 32'sd46385103},
        '{-32'sd693787154, 32'sd638410160, 32'sd92452649, -32'sd37206474},
        '{32'sd85360580, -32'sd185804251, 32'sd115886765, -32'sd15455416},
        '{-32'sd4675182, 32'sd15235996, -32'sd16827571, 32'sd6280000}
    };

    typedef enum logic [IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_START_W = 3'd3,
        REG_END_X   = 3'd4,
        REG_END_Y   = 3'd5,
        REG_END_Z   = 3'd6,
        REG_END_W   = 3'd7
    } reg_idx_t;

endpackage

// ----- rtl/core/swpa_coef.sv -----
// Per-configuration constant block: dot product, reciprocal and coefficients.
// Recomputed sequentially after every configuration write; the top level only
// accepts items when done.
module swpa_coef #(
    parameter int DATA_WIDTH = 24,
    parameter int FRAC_BITS  = 22
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] qa [4],
    input  logic signed [DATA_WIDTH-1:0] qb [4],
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] recip,
    output logic                         degen,
    output logic signed [DATA_WIDTH-1:0] coef [4]
);
    localparam int PW = 2 * DATA_WIDTH + 2;
    localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);
    localparam logic signed [PW-1:0] ONE = PW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam int QW = 2 * FRAC_BITS + 2;
    localparam int CW = $clog2(QW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DOT  = 6'b000010,
        S_DIVS = 6'b000100,
        S_DIV  = 6'b001000,
        S_POLY = 6'b010000,
        S_DONE = 6'b100000
    } cst_t;

    function automatic logic signed [PW-1:0] sat_f(input logic signed [PW-1:0] v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    function automatic logic signed [PW-1:0] cst_f(input logic signed [31:0] c);
        logic signed [PW+8:0] w;
        w = ((PW+9)'(c) + ((PW+9)'(1) <<< (swpa_pkg::CONST_FRAC - FRAC_BITS - 1)))
            >>> (swpa_pkg::CONST_FRAC - FRAC_BITS);
        if (w > (PW+9)'(MAXV)) return MAXV;
        if (w < (PW+9)'(MINV)) return MINV;
        return PW'(w);
    endfunction

    cst_t st_reg, st_next;
    logic [2:0] cnt_reg;
    logic [1:0] term_reg;
    logic [CW-1:0] bit_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] d_reg;
    logic [QW-1:0] rem_reg, quo_reg, den_reg;
    logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
    logic signed [2*DATA_WIDTH-1:0] prod;
    logic signed [PW-1:0] prod_r;
    logic [QW:0] trial;

    // accumulator and d stay inside the data range while the multiplier is used
    assign mul_a = (st_reg == S_DOT) ? qa[cnt_reg[1:0]] : DATA_WIDTH'(acc_reg);
    assign mul_b = (st_reg == S_DOT) ? qb[cnt_reg[1:0]] : DATA_WIDTH'(d_reg);
    assign prod = mul_a * mul_b;
    assign prod_r = PW'((prod + (2*DATA_WIDTH)'(HALF)) >>> FRAC_BITS);
    assign trial = {rem_reg, quo_reg[QW-1]} - {1'b0, den_reg};
    assign done = (st_reg == S_DONE);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: st_next = S_DOT;
            S_DOT:  if (cnt_reg == 3'd4) st_next = S_DIVS;
            S_DIVS: st_next = S_DIV;
            S_DIV:  if (bit_reg == CW'(QW)) st_next = S_POLY;
            S_POLY: if (term_reg == 2'd3 && cnt_reg == 3'd3) st_next = S_DONE;
            S_DONE: st_next = S_DONE;
            default: st_next = S_IDLE;
        endcase
        if (start) st_next = S_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
        case (st_reg)
            S_IDLE: begin
                cnt_reg <= '0;
                acc_reg <= '0;
            end
            S_DOT: begin
                if (cnt_reg == 3'd4) begin
                    d_reg <= sat_f(acc_reg);
                end else begin
                    acc_reg <= acc_reg + prod_r;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
            S_DIVS: begin
                acc_reg <= sat_f(ONE + d_reg);
                den_reg <= QW'(sat_f(ONE + d_reg));
                // numerator ONE*ONE plus half the divisor, shifted in bit by bit
                quo_reg <= (QW'(1) << (2 * FRAC_BITS))
                           + (QW'(sat_f(ONE + d_reg)) >> 1);
                rem_reg <= '0;
                bit_reg <= '0;
            end
            S_DIV: begin
                if (bit_reg == CW'(QW)) begin
                    if (acc_reg <= 0 || quo_reg > QW'(MAXV)) begin
                        recip <= DATA_WIDTH'(MAXV);
                        degen <= 1'b1;
                    end else begin
                        recip <= DATA_WIDTH'(quo_reg);
                        degen <= 1'b0;
                    end
                    term_reg <= '0;
                    cnt_reg <= '0;
                    acc_reg <= cst_f(swpa_pkg::COEF_TAB[0][3]);
                end else begin
                    bit_reg <= bit_reg + CW'(1);
                    if (!trial[QW]) begin
                        rem_reg <= trial[QW-1:0];
                        quo_reg <= {quo_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[QW-2:0], quo_reg[QW-1]};
                        quo_reg <= {quo_reg[QW-2:0], 1'b0};
                    end
                end
            end
            S_POLY: begin
                if (cnt_reg == 3'd3) begin
                    coef[term_reg] <= DATA_WIDTH'(acc_reg);
                    cnt_reg <= '0;
                    if (term_reg != 2'd3) begin
                        acc_reg <= cst_f(swpa_pkg::COEF_TAB[term_reg + 2'd1][3]);
                        term_reg <= term_reg + 2'd1;
                    end
                end else begin
                    acc_reg <= sat_f(cst_f(swpa_pkg::COEF_TAB[term_reg][2'd2 - cnt_reg[1:0]])
                                     + sat_f(prod_r));
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- rtl/core/swpa_mul.sv -----
// Registered fixed-point multiply-add with round half up and saturation.
module swpa_mul #(
    parameter int DATA_WIDTH = 24,
    parameter int FRAC_BITS  = 22
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    input  logic signed [DATA_WIDTH-1:0] addend,
    output logic signed [DATA_WIDTH-1:0] y
);
    localparam int PW = 2 * DATA_WIDTH + 2;
    localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);
    logic signed [2*DATA_WIDTH-1:0] p;
    logic signed [PW-1:0] r, s;

    always_comb begin
        p = a * b;
        r = PW'((p + ((2*DATA_WIDTH)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        if (r > MAXV) r = MAXV;
        if (r < MINV) r = MINV;
        s = r + PW'(addend);
        if (s > MAXV) s = MAXV;
        if (s < MINV) s = MINV;
    end

    always_ff @(posedge aclk) begin
        if (en) y <= DATA_WIDTH'(s);
    end
endmodule

// ----- rtl/core/slerp_weight_poly_approx_top.sv -----
// Approximate quaternion slerp in Q2.22 fixed point.
// Configuration channel: cfg_valid/cfg_ready with cfg_index (0..3 start x,y,z,w,
// 4..7 end x,y,z,w) and cfg_data. After the last write the block recomputes the
// dot product, reciprocal of 1+d and polynomial coefficients; s_tready stays low
// during that time.
// Input channel s_: tdata holds blend_t (23 bits). Output channel m_: tdata
// holds out_x, out_y, out_z, out_w; tuser holds degenerate.
// Throughput is one item per cycle while the output is not stalled; a result passes
// through the input register, square, three Horner stages, times u, weight,
// component products, and sum and saturate.
// Reset clears all valid bits, loads identity quaternions and starts the
// coefficient computation. While m_tvalid is high and m_tready low the whole pipeline holds,
// so nothing is lost or repeated.
module slerp_weight_poly_approx_top #(
    parameter int DATA_WIDTH = 24,
    parameter int FRAC_BITS  = 22
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [DATA_WIDTH-1:0]   cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [((DATA_WIDTH+6)/8)*8-1:0] s_tdata,  // blend_t
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata, // out_x, out_y, out_z, out_w
    output logic [7:0]              m_tuser             // degenerate
);
    localparam int W = DATA_WIDTH;
    localparam int NST = 9;
    localparam int UD = 5;
    localparam int PW = 2 * W + 2;
    localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);
    localparam logic signed [2*W-1:0] HALF = (2*W)'(64'sd1 <<< (FRAC_BITS - 1));
    localparam int OW = ((4 * W + 7) / 8) * 8;

    logic signed [W-1:0] regs_reg [swpa_pkg::NUM_REGS];
    logic signed [W-1:0] qa [4], qb [4], coef [4], recip;
    logic degen, cdone, start_reg, en;
    logic [NST-1:0] vld_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < swpa_pkg::NUM_REGS; i++) regs_reg[i] <= '0;
            regs_reg[swpa_pkg::REG_START_W] <= ONE;
            regs_reg[swpa_pkg::REG_END_W] <= ONE;
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_valid;
            if (cfg_valid) regs_reg[cfg_index] <= cfg_data;
        end
    end
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qa[i] = regs_reg[i];
            qb[i] = regs_reg[i + 4];
        end
    end

    swpa_coef #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_coef (
        .aclk, .aresetn, .start(start_reg), .qa, .qb,
        .done(cdone), .recip, .degen, .coef
    );

    // Pipeline: two lanes (u = 1-t and u = t) of Horner steps.
    assign en = !m_tvalid || m_tready;
    assign s_tready = en && cdone && !start_reg && !cfg_valid;

    logic [W-2:0] t_in;
    logic signed [W-1:0] t0, tc0;
    always_comb begin
        t_in = s_tdata[W-2:0];
        if (t_in > (W-1)'(ONE)) t_in = (W-1)'(ONE);
        t0 = W'(t_in);
        tc0 = ONE - t0;
    end

    logic signed [W-1:0] u_reg [2][UD];
    logic signed [W-1:0] u2 [2], p1 [2], p2 [2], p3 [2], p4 [2], wt [2];
    logic signed [W-1:0] zero;
    assign zero = '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0][0] <= tc0;
            u_reg[1][0] <= t0;
            for (int k = 1; k < UD; k++) begin
                u_reg[0][k] <= u_reg[0][k-1];
                u_reg[1][k] <= u_reg[1][k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        swpa_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_sq (
            .aclk, .en, .a(u_reg[l][0]), .b(u_reg[l][0]), .addend(zero), .y(u2[l]));
        swpa_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_h1 (
            .aclk, .en, .a(coef[3]), .b(u2[l]), .addend(coef[2]), .y(p1[l]));
        logic signed [W-1:0] u2d1, u2d2;
        always_ff @(posedge aclk) begin
            if (en) begin
                u2d1 <= u2[l];
                u2d2 <= u2d1;
            end
        end
        swpa_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_h2 (
            .aclk, .en, .a(p1[l]), .b(u2d1), .addend(coef[1]), .y(p2[l]));
        swpa_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_h3 (
            .aclk, .en, .a(p2[l]), .b(u2d2), .addend(coef[0]), .y(p3[l]));
        swpa_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_h4 (
            .aclk, .en, .a(p3[l]), .b(u_reg[l][4]), .addend(zero), .y(p4[l]));
        swpa_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_w (
            .aclk, .en, .a(p4[l]), .b(recip), .addend(zero), .y(wt[l]));
    end

    // Stage 7: products with quaternion components, stage 8: sum and saturate.
    logic signed [2*W-1:0] ma [4], mb [4];
    logic signed [PW-1:0] pa_reg [4], pb_reg [4];
    logic signed [W-1:0] o_reg [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ma[i] = wt[0] * qa[i];
            mb[i] = wt[1] * qb[i];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                pa_reg[i] <= PW'((ma[i] + HALF) >>> FRAC_BITS);
                pb_reg[i] <= PW'((mb[i] + HALF) >>> FRAC_BITS);
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                if (pa_reg[i] + pb_reg[i] > MAXV) o_reg[i] <= W'(MAXV);
                else if (pa_reg[i] + pb_reg[i] < MINV) o_reg[i] <= W'(MINV);
                else o_reg[i] <= W'(pa_reg[i] + pb_reg[i]);
            end
        end
    end

    // Valid travels: stage 0 input, 1 square, 2..4 Horner, 5 times u,
    // 6 weight, 7 products, 8 output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid && s_tready};
        end
    end
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata = OW'({o_reg[3], o_reg[2], o_reg[1], o_reg[0]});
    assign m_tuser = {7'd0, degen};

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed during stall");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> cdone)
        else $error("item taken while coefficients busy");
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> !s_tready)
        else $error("item taken right after configuration write");
endmodule

// ----- test/tb.sv -----
module tb;
    localparam int DW = 24;
    localparam int FB = 22;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam int ONE_I = 1 << FB;
    localparam longint MAXV = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint MINV = -MAXV - 1;
    localparam int LIMIT = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;
    logic [7:0] m_tuser;

    always #1 aclk = ~aclk;

    slerp_weight_poly_approx_top uut (.*);

    typedef struct packed {
        logic signed [DW-1:0] qw, qz, qy, qx;
        logic degen;
    } slerp_out_t;

    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_sink = 0;
    longint qreg [8];

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint sat(longint v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    // round half up, floor division by 2^s
    function automatic longint rnd_shift(longint v, int s);
        longint w;
        w = v + (64'sd1 <<< (s - 1));
        return w >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat(rnd_shift(a * b, FB));
    endfunction

    function automatic longint cubic_coef(int k, longint d);
        longint acc;
        acc = sat(rnd_shift(longint'(swpa_pkg::COEF_TAB[k][3]), swpa_pkg::CONST_FRAC - FB));
        for (int i = 2; i >= 0; i--)
            acc = sat(sat(rnd_shift(longint'(swpa_pkg::COEF_TAB[k][i]),
                                    swpa_pkg::CONST_FRAC - FB)) + qmul(acc, d));
        return acc;
    endfunction

    function automatic longint blend_weight(longint c[4], longint u, longint r);
        longint u2, p;
        u2 = qmul(u, u);
        p = sat(c[2] + qmul(c[3], u2));
        p = sat(c[1] + qmul(p, u2));
        p = sat(c[0] + qmul(p, u2));
        p = qmul(p, u);
        return qmul(p, r);
    endfunction

    function automatic slerp_out_t predict_slerp(logic [22:0] tin);
        slerp_out_t o;
        longint d, s, r, t, alpha, beta, v;
        longint c[4];
        d = 0;
        for (int i = 0; i < 4; i++) d += rnd_shift(qreg[i] * qreg[i+4], FB);
        d = sat(d);
        s = sat(ONE_Q + d);
        o.degen = 0;
        if (s <= 0) begin
            o.degen = 1;
            r = MAXV;
        end else begin
            r = ((64'sd1 <<< (2 * FB)) + (s >> 1)) / s;
            if (r > MAXV) begin
                o.degen = 1;
                r = MAXV;
            end
        end
        for (int k = 0; k < 4; k++) c[k] = cubic_coef(k, d);
        t = tin;
        if (t > ONE_Q) t = ONE_Q;
        alpha = blend_weight(c, sat(ONE_Q - t), r);
        beta = blend_weight(c, sat(t), r);
        for (int i = 0; i < 4; i++) begin
            v = sat(rnd_shift(alpha * qreg[i], FB) + rnd_shift(beta * qreg[i+4], FB));
            case (i)
                0: o.qx = v[DW-1:0];
                1: o.qy = v[DW-1:0];
                2: o.qz = v[DW-1:0];
                default: o.qw = v[DW-1:0];
            endcase
        end
        return o;
    endfunction

    class slerp_scoreboard;
        slerp_out_t pending [$];
        function void note_blend(logic [22:0] t);
            pending.push_back(predict_slerp(t));
        endfunction
        task check_result(logic [95:0] data, logic [7:0] user);
            slerp_out_t e;
            if (pending.size() == 0) begin
                report("unexpected result", data[23:0], 0);
                return;
            end
            e = pending.pop_front();
            if ($signed(data[23:0]) != e.qx) report("out_x", $signed(data[23:0]), e.qx);
            if ($signed(data[47:24]) != e.qy) report("out_y", $signed(data[47:24]), e.qy);
            if ($signed(data[71:48]) != e.qz) report("out_z", $signed(data[71:48]), e.qz);
            if ($signed(data[95:72]) != e.qw) report("out_w", $signed(data[95:72]), e.qw);
            if (user[0] != e.degen) report("degenerate", user[0], e.degen);
        endtask
    endclass

    slerp_scoreboard sb = new();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_blend(s_tdata[22:0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
                $display("slerp_weight_poly_approx_top verification failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, a long hold-off on request
    initial begin : sink
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 8);
                m_tready <= 0;
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(swpa_pkg::reg_idx_t idx, longint val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val[DW-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        qreg[idx] = longint'($signed(val[DW-1:0]));
    endtask

    task automatic send_blend(logic [22:0] t);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [22:0] rand_blend();
        case ($urandom_range(0, 5))
            0: return 23'($urandom_range(0, 8));
            1: return 23'(ONE_I - int'($urandom_range(0, 8)));
            2: return 23'($urandom);
            default: return 23'($urandom_range(0, ONE_I));
        endcase
    endfunction

    function automatic longint rand_comp(int mode);
        case (mode)
            0: return longint'($signed(24'($urandom)));
            1: return longint'($urandom_range(0, 2 * ONE_I)) - ONE_Q;
            default: return longint'($urandom_range(0, ONE_I)) - ONE_Q / 2;
        endcase
    endfunction

    initial begin : stim
        logic [22:0] directed [$];
        longint q [8];
        int mode;
        for (int i = 0; i < 8; i++) qreg[i] = 0;
        qreg[swpa_pkg::REG_START_W] = ONE_Q;
        qreg[swpa_pkg::REG_END_W] = ONE_Q;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        directed = '{23'd0, 23'd1, 23'h200000, 23'h3fffff, 23'h400000,
                     23'h400001, 23'h7fffff, 23'h555555};
        foreach (directed[i]) send_blend(directed[i]);
        drain();

        // antipodal, then extreme register patterns, then random ones
        for (int ph = 0; ph < 16; ph++) begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 8; i++) q[i] = rand_comp(mode);
            case (ph)
                0: begin
                    for (int i = 0; i < 8; i++) q[i] = 0;
                    q[3] = ONE_Q;
                    q[7] = -ONE_Q;
                end
                1: for (int i = 0; i < 8; i++) q[i] = MAXV;
                2: for (int i = 0; i < 8; i++) q[i] = (i < 4) ? MINV : MAXV;
                3: for (int i = 0; i < 8; i++) q[i] = MINV;
                4: begin
                    for (int i = 0; i < 8; i++) q[i] = 0;
                    q[0] = ONE_Q;
                    q[4] = -ONE_Q + 3;
                end
                default: ;
            endcase
            for (int i = 0; i < 8; i++) write_reg(swpa_pkg::reg_idx_t'(i), q[i]);
            cfg_valid <= 0;
            if (ph == 0) foreach (directed[i]) send_blend(directed[i]);
            if (ph == 6) hold_sink = 1;
            if (ph == 14) quiet = 1;
            repeat (95) send_blend(rand_blend());
            drain();
        end

        if (errors == 0 && sb.pending.size() == 0)
            $display("slerp_weight_poly_approx_top verification clean");
        else
            $display("slerp_weight_poly_approx_top verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/swpa_pkg.sv
rtl/core/swpa_coef.sv
rtl/core/swpa_mul.sv
rtl/core/slerp_weight_poly_approx_top.sv
test/tb.sv
